### rtl/core/jbrf_pkg.sv
// ----------------------------------------------------------------------------
// jbrf_pkg
// shared types, constants and helpers of the j1939 bam reassembly filter
// ----------------------------------------------------------------------------
package jbrf_pkg;

  localparam int MAX_PACKETS = 16;
  localparam int STORE_DEPTH = 2 * MAX_PACKETS;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);
  localparam int IDX_W       = $clog2(MAX_PACKETS);
  localparam int CNT_W       = IDX_W + 1;

  localparam int PGN_W       = 18;
  localparam int DATA_W      = 64;

  localparam logic [15:0] PGN_TPCM    = 16'hEC00;
  localparam logic [15:0] PGN_TPDT    = 16'hEB00;
  localparam logic [7:0]  BAM_CONTROL = 8'd32;
  localparam logic [7:0]  PF_PDU2     = 8'd240;
  localparam logic [7:0]  SA_ENGINE   = 8'h00;
  localparam logic [7:0]  SA_RET_A    = 8'h10;
  localparam logic [7:0]  SA_RET_B    = 8'h0F;
  localparam logic [7:0]  ENG_DEFAULT_PACKETS = 8'd4;
  localparam logic [7:0]  RET_DEFAULT_PACKETS = 8'd3;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_GENERIC_MODE = 3'd0,
    CFG_FILTER_COUNT = 3'd1,
    CFG_KEEP_PGN_0   = 3'd2,
    CFG_KEEP_PGN_1   = 3'd3,
    CFG_KEEP_PGN_2   = 3'd4,
    CFG_KEEP_PGN_3   = 3'd5,
    CFG_ENGINE_PGN   = 3'd6,
    CFG_RETARDER_PGN = 3'd7
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_SINGLE   = 2'd0,
    KIND_COMPLETE = 2'd1,
    KIND_FLUSH    = 2'd2
  } kind_t;

  // operand select of the shared pgn comparator
  typedef enum logic [2:0] {
    SEL_KEEP0 = 3'd0,
    SEL_KEEP1 = 3'd1,
    SEL_KEEP2 = 3'd2,
    SEL_KEEP3 = 3'd3,
    SEL_ENG   = 3'd4,
    SEL_RET   = 3'd5
  } cmp_sel_t;

  typedef struct packed {
    logic                 generic_mode;
    logic [2:0]           filter_count;
    logic [3:0][PGN_W-1:0] keep_pgn;
    logic [PGN_W-1:0]     engine_pgn;
    logic [PGN_W-1:0]     retarder_pgn;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] payload;
    logic [7:0]        id_source;
    logic [7:0]        id_specific;
    logic [7:0]        id_format;
  } frame_t;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] wdata;
  } store_req_t;

  typedef struct packed {
    kind_t             kind;
    logic [PGN_W-1:0]  pgn;
    logic [DATA_W-1:0] data;
    logic              last;
  } result_t;

  function automatic logic [ADDR_W-1:0] store_addr(input logic ctx,
                                                   input logic [IDX_W-1:0] idx);
    store_addr = ctx ? (ADDR_W'(MAX_PACKETS) + ADDR_W'(idx)) : ADDR_W'(idx);
  endfunction

  function automatic logic [CNT_W-1:0] sat_count(input logic [7:0] cnt);
    sat_count = (cnt > 8'(MAX_PACKETS)) ? CNT_W'(MAX_PACKETS) : CNT_W'(cnt);
  endfunction

endpackage

### rtl/core/jbrf_cmp.sv
// ----------------------------------------------------------------------------
// jbrf_cmp
// shared pgn equality unit, operand picked from the configuration registers
// ----------------------------------------------------------------------------
module jbrf_cmp (
  input  logic [jbrf_pkg::PGN_W-1:0] key,
  input  jbrf_pkg::cmp_sel_t         sel,
  input  jbrf_pkg::cfg_t             cfg,
  output logic                       eq
);
  import jbrf_pkg::*;

  logic [PGN_W-1:0] operand;

  always_comb begin
    unique case (sel)
      SEL_KEEP0: operand = cfg.keep_pgn[0];
      SEL_KEEP1: operand = cfg.keep_pgn[1];
      SEL_KEEP2: operand = cfg.keep_pgn[2];
      SEL_KEEP3: operand = cfg.keep_pgn[3];
      SEL_ENG:   operand = cfg.engine_pgn;
      SEL_RET:   operand = cfg.retarder_pgn;
      default:   operand = ~key;
    endcase
  end

  assign eq = (key == operand);

endmodule

### rtl/core/jbrf_store.sv
// ----------------------------------------------------------------------------
// jbrf_store
// packet store of both contexts, one port, registered read, valid per entry
// ----------------------------------------------------------------------------
module jbrf_store (
  input  logic                        clk,
  input  logic                        rst,
  input  jbrf_pkg::store_req_t        req,
  output logic [jbrf_pkg::DATA_W-1:0] rdata
);
  import jbrf_pkg::*;

  logic [DATA_W-1:0]      mem [STORE_DEPTH];
  logic [STORE_DEPTH-1:0] valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (req.wr_en) begin
      valid[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rdata <= valid[req.addr] ? mem[req.addr] : '0;
    end
  end

endmodule

### rtl/core/jbrf_seq.sv
// ----------------------------------------------------------------------------
// jbrf_seq
// frame sequencer: decode, context update, filter steps and store read-out
// ----------------------------------------------------------------------------
module jbrf_seq (
  input  logic                        clk,
  input  logic                        rst,
  input  jbrf_pkg::cfg_t              cfg,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  jbrf_pkg::frame_t            frame_in,
  output logic                        res_valid,
  input  logic                        res_ready,
  output jbrf_pkg::result_t           res,
  output jbrf_pkg::store_req_t        st_req,
  input  logic [jbrf_pkg::DATA_W-1:0] st_rdata
);
  import jbrf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b00_0000_0001,
    S_DECODE    = 10'b00_0000_0010,
    S_MATCH_ENG = 10'b00_0000_0100,
    S_MATCH_RET = 10'b00_0000_1000,
    S_BAM_SET   = 10'b00_0001_0000,
    S_DT_STORE  = 10'b00_0010_0000,
    S_FILT      = 10'b00_0100_0000,
    S_OUT       = 10'b00_1000_0000,
    S_RD        = 10'b01_0000_0000,
    S_EMIT      = 10'b10_0000_0000
  } state_t;

  state_t           state;
  frame_t           frame;
  logic [PGN_W-1:0] key;
  logic             ctx;
  kind_t            kind;
  logic [CNT_W-1:0] emit_n;
  logic [IDX_W-1:0] idx;
  logic [1:0]       fi;

  logic             ctx_active [2];
  logic [7:0]       ctx_count  [2];
  logic [PGN_W-1:0] ctx_pgn    [2];

  logic [15:0]      pgn16;
  logic [7:0]       seq_no;
  logic             seq_ok;
  logic [7:0]       bam_count;
  logic             bam_count_ok;
  logic [7:0]       eff_count;
  logic [PGN_W-1:0] eff_pgn;
  logic [2:0]       lim;
  cmp_sel_t         cmp_sel;
  logic             cmp_eq;
  logic             accept;

  jbrf_cmp u_cmp (
    .key (key),
    .sel (cmp_sel),
    .cfg (cfg),
    .eq  (cmp_eq)
  );

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);

  assign pgn16        = (frame.id_format < PF_PDU2) ? {frame.id_format, 8'h00}
                                                    : {frame.id_format, frame.id_specific};
  assign seq_no       = frame.payload[7:0];
  assign seq_ok       = (seq_no != 8'd0) && (seq_no <= 8'(MAX_PACKETS));
  assign bam_count    = frame.payload[31:24];
  assign bam_count_ok = (bam_count != 8'd0) && (bam_count <= 8'(MAX_PACKETS));

  // context as it stands once a data frame without announce has opened it
  assign eff_count = ctx_active[ctx] ? ctx_count[ctx]
                   : (ctx ? RET_DEFAULT_PACKETS : ENG_DEFAULT_PACKETS);
  assign eff_pgn   = ctx_active[ctx] ? ctx_pgn[ctx]
                   : (ctx ? cfg.retarder_pgn : cfg.engine_pgn);

  // single frames check the whole keep list, messages only the first entry
  always_comb begin
    if (kind == KIND_SINGLE) begin
      lim = (cfg.filter_count > 3'd4) ? 3'd4 : cfg.filter_count;
    end else begin
      lim = {2'b00, cfg.filter_count != 3'd0};
    end
  end

  always_comb begin
    unique case (state)
      S_MATCH_ENG: cmp_sel = SEL_ENG;
      S_MATCH_RET: cmp_sel = SEL_RET;
      default:     cmp_sel = cmp_sel_t'({1'b0, fi});
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      ctx_active[0] <= 1'b0;
      ctx_active[1] <= 1'b0;
      ctx_count[0]  <= '0;
      ctx_count[1]  <= '0;
      ctx_pgn[0]    <= '0;
      ctx_pgn[1]    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            frame <= frame_in;
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          kind <= KIND_SINGLE;
          fi   <= '0;
          if (cfg.generic_mode) begin
            key   <= PGN_W'(pgn16);
            state <= S_OUT;
          end else if (pgn16 == PGN_TPCM && frame.payload[7:0] == BAM_CONTROL) begin
            // announced pgn wider than a register never matches
            key <= frame.payload[57:40];
            if (frame.payload[63:58] != '0) begin
              state <= S_IDLE;
            end else begin
              state <= S_MATCH_ENG;
            end
          end else if (pgn16 == PGN_TPDT) begin
            ctx <= (frame.id_source != SA_ENGINE);
            if (seq_ok && (frame.id_source == SA_ENGINE ||
                           frame.id_source == SA_RET_A ||
                           frame.id_source == SA_RET_B)) begin
              state <= S_DT_STORE;
            end else begin
              state <= S_IDLE;
            end
          end else begin
            key   <= PGN_W'(pgn16);
            state <= S_FILT;
          end
        end
        S_MATCH_ENG: begin
          ctx <= 1'b0;
          state <= cmp_eq ? S_BAM_SET : S_MATCH_RET;
        end
        S_MATCH_RET: begin
          ctx <= 1'b1;
          state <= cmp_eq ? S_BAM_SET : S_IDLE;
        end
        S_BAM_SET: begin
          ctx_pgn[ctx]   <= key;
          ctx_count[ctx] <= bam_count;
          emit_n         <= sat_count(ctx_count[ctx]);
          kind           <= KIND_FLUSH;
          fi             <= '0;
          if (bam_count_ok) begin
            ctx_active[ctx] <= 1'b1;
          end
          state <= ctx_active[ctx] ? S_FILT : S_IDLE;
        end
        S_DT_STORE: begin
          ctx_active[ctx] <= 1'b1;
          ctx_count[ctx]  <= eff_count;
          ctx_pgn[ctx]    <= eff_pgn;
          key             <= eff_pgn;
          emit_n          <= CNT_W'(seq_no);
          kind            <= KIND_COMPLETE;
          fi              <= '0;
          state <= (seq_no == eff_count) ? S_FILT : S_IDLE;
        end
        S_FILT: begin
          if (lim == 3'd0 || cmp_eq) begin
            idx <= '0;
            if (kind == KIND_SINGLE) begin
              state <= S_OUT;
            end else begin
              if (kind == KIND_COMPLETE) begin
                ctx_active[ctx] <= 1'b0;
                ctx_count[ctx]  <= '0;
              end
              state <= (emit_n == '0) ? S_IDLE : S_RD;
            end
          end else if ({1'b0, fi} == lim - 3'd1) begin
            state <= S_IDLE;
          end else begin
            fi <= fi + 2'd1;
          end
        end
        S_OUT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        S_RD: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (res_ready) begin
            if (res.last) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx + IDX_W'(1);
              state <= S_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    st_req.wr_en = (state == S_DT_STORE);
    st_req.rd_en = (state == S_RD);
    st_req.addr  = (state == S_DT_STORE) ? store_addr(ctx, IDX_W'(seq_no - 8'd1))
                                         : store_addr(ctx, idx);
    st_req.wdata = frame.payload;
  end

  assign res_valid = (state == S_OUT) || (state == S_EMIT);

  always_comb begin
    res.kind = kind;
    res.pgn  = key;
    if (state == S_OUT) begin
      res.data = frame.payload;
      res.last = 1'b1;
    end else begin
      res.data = st_rdata;
      res.last = ((CNT_W'(idx) + CNT_W'(1)) == emit_n);
    end
  end

  a_ready_no_result: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !res_valid)
    else $error("sequencer ready for a frame while a result is pending");

  a_read_then_emit: assert property (@(posedge clk) disable iff (rst)
    st_req.rd_en |=> state == S_EMIT)
    else $error("store read not followed by an emit step");

  a_write_after_decode: assert property (@(posedge clk) disable iff (rst)
    st_req.wr_en |-> $past(state) == S_DECODE)
    else $error("store written outside a data frame");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready && res.last |=> in_ready)
    else $error("sequencer not idle after final result");

endmodule

### rtl/core/j1939_bam_reassembly_filter_core.sv
// ----------------------------------------------------------------------------
// j1939_bam_reassembly_filter_core
// j1939 broadcast announce reassembly with pgn keep-list filtering
// ----------------------------------------------------------------------------
// One received frame per input transaction. A frame is registered, then
// decoded, and its compares all run one at a time through a single pgn
// comparator: an announce passes the engine match and, on a miss, the
// retarder match before its context is updated, a plain frame up to four
// keep-list steps. A completed or flushed message is then read out of the
// single-port packet store one stored packet at a time (read, then hand over
// to the output register, which may stall on back-pressure). The block takes
// no new frame until every result transaction of the current frame has
// entered the output register; one finished result may wait there while the
// next frame is taken. Store entries carry valid bits cleared by reset, so
// there is no clearing pass. Configuration writes are always taken and belong
// to idle periods.
module j1939_bam_reassembly_filter_core (
  input  logic        clk,
  input  logic        rst,
  // frame input
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // id_format, id_specific, id_source, payload
  // result output
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [87:0] m_tdata,   // msg_pgn, frame_payload, zero fill
  output logic [1:0]  m_tuser,   // kind
  output logic        m_tlast,   // last
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [17:0] cfg_data
);
  import jbrf_pkg::*;

  cfg_t                cfg;
  frame_t              frame_in;
  result_t             res;
  logic                res_valid;
  logic                res_ready;
  store_req_t          st_req;
  logic [DATA_W-1:0]   st_rdata;
  result_t             out_reg;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.generic_mode <= 1'b0;
      cfg.filter_count <= '0;
      cfg.keep_pgn     <= '0;
      cfg.engine_pgn   <= PGN_W'(65251);
      cfg.retarder_pgn <= PGN_W'(65249);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_GENERIC_MODE: cfg.generic_mode <= cfg_data[0];
        CFG_FILTER_COUNT: cfg.filter_count <= cfg_data[2:0];
        CFG_KEEP_PGN_0:   cfg.keep_pgn[0]  <= cfg_data;
        CFG_KEEP_PGN_1:   cfg.keep_pgn[1]  <= cfg_data;
        CFG_KEEP_PGN_2:   cfg.keep_pgn[2]  <= cfg_data;
        CFG_KEEP_PGN_3:   cfg.keep_pgn[3]  <= cfg_data;
        CFG_ENGINE_PGN:   cfg.engine_pgn   <= cfg_data;
        CFG_RETARDER_PGN: cfg.retarder_pgn <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack the input transaction
  assign frame_in.id_format   = s_tdata[7:0];
  assign frame_in.id_specific = s_tdata[15:8];
  assign frame_in.id_source   = s_tdata[23:16];
  assign frame_in.payload     = s_tdata[87:24];

  jbrf_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .frame_in  (frame_in),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .st_req    (st_req),
    .st_rdata  (st_rdata)
  );

  jbrf_store u_store (
    .clk   (clk),
    .rst   (rst),
    .req   (st_req),
    .rdata (st_rdata)
  );

  // output register, refilled as soon as the held transaction leaves
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_reg <= res;
    end
  end

  assign m_tdata = {6'b0, out_reg.data, out_reg.pgn};
  assign m_tuser = out_reg.kind;
  assign m_tlast = out_reg.last;

endmodule
